// File: hdl/wis_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and widths for the weighted index sampler.
package wis_pkg;

  localparam int unsigned MaxCellsDefault = 4096;

  localparam int unsigned TotalW    = 48;
  localparam int unsigned VolW      = 32;
  localparam int unsigned FracW     = 32;
  localparam int unsigned CountW    = 24;
  localparam int unsigned IndexOutW = 12;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_SAMPLE,
    OP_COUNT
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_NONPOS,
    STAT_EMPTY,
    STAT_FULL
  } status_e;

  typedef enum logic [1:0] {
    CFG_DENSITY,
    CFG_USE_FIXED,
    CFG_FIXED_COUNT
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_SEARCH
  } state_e;

  typedef enum logic [1:0] {
    MS_IDLE,
    MS_LO,
    MS_HI,
    MS_SUM
  } mul_step_e;

  typedef struct packed {
    logic valid;
    logic round;
  } mul_req_t;

endpackage

// File: hdl/wis_table_ram.sv
`timescale 1ns / 1ps
// Prefix table memory: one write port, one registered read port.
module wis_table_ram #(
  parameter int unsigned Depth = wis_pkg::MaxCellsDefault,
  parameter int unsigned AddrW = $clog2(Depth),
  parameter int unsigned DataW = wis_pkg::TotalW
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/wis_mul.sv
`timescale 1ns / 1ps
// Multi-cycle signed 48 x unsigned 32 multiply, scaled down by 2^32 with optional rounding.
module wis_mul (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  wis_pkg::mul_req_t                     req_i,
  input  logic signed [wis_pkg::TotalW-1:0]     x_i,
  input  logic        [wis_pkg::FracW-1:0]      y_i,
  output logic                                  done_o,
  output logic signed [wis_pkg::TotalW-1:0]     res_o
);

  localparam int unsigned TotalW = wis_pkg::TotalW;
  localparam int unsigned FracW  = wis_pkg::FracW;
  localparam int unsigned HalfW  = TotalW / 2;
  localparam int unsigned PartW  = HalfW + 1;
  localparam int unsigned OpbW   = FracW + 1;
  localparam int unsigned ProdW  = PartW + OpbW;
  localparam int unsigned LoW    = HalfW + FracW;
  localparam int unsigned SumW   = ProdW + HalfW;

  wis_pkg::mul_step_e step_q, step_d;

  logic [TotalW-1:0]              x_q;
  logic [FracW-1:0]               y_q;
  logic                           rnd_q;
  logic [LoW-1:0]                 lo_q;
  logic signed [ProdW-1:0]        hi_q;
  logic signed [TotalW-1:0]       res_q;
  logic                           done_q, done_d;

  logic                           ld_in, ld_lo, ld_hi;
  logic signed [PartW-1:0]        opa;
  logic signed [OpbW-1:0]         opb;
  logic signed [ProdW-1:0]        prod;
  logic signed [SumW-1:0]         sum;

  always_comb begin
    step_d = step_q;
    case (step_q)
      wis_pkg::MS_IDLE: begin
        if (req_i.valid) begin
          step_d = wis_pkg::MS_LO;
        end
      end
      wis_pkg::MS_LO:  step_d = wis_pkg::MS_HI;
      wis_pkg::MS_HI:  step_d = wis_pkg::MS_SUM;
      wis_pkg::MS_SUM: step_d = wis_pkg::MS_IDLE;
      default:         step_d = wis_pkg::MS_IDLE;
    endcase
  end

  always_comb begin
    ld_in  = 1'b0;
    ld_lo  = 1'b0;
    ld_hi  = 1'b0;
    done_d = 1'b0;
    case (step_q)
      wis_pkg::MS_IDLE: ld_in  = req_i.valid;
      wis_pkg::MS_LO:   ld_lo  = 1'b1;
      wis_pkg::MS_HI:   ld_hi  = 1'b1;
      wis_pkg::MS_SUM:  done_d = 1'b1;
      default: ;
    endcase
  end

  assign opa  = (step_q == wis_pkg::MS_LO) ? $signed({1'b0, x_q[HalfW-1:0]})
                                           : $signed({x_q[TotalW-1], x_q[TotalW-1:HalfW]});
  assign opb  = $signed({1'b0, y_q});
  assign prod = opa * opb;

  assign sum = $signed({hi_q, {HalfW{1'b0}}})
             + $signed({{(SumW-LoW){1'b0}}, lo_q})
             + $signed({{(SumW-FracW){1'b0}}, rnd_q, {(FracW-1){1'b0}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= wis_pkg::MS_IDLE;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_in) begin
      x_q   <= x_i;
      y_q   <= y_i;
      rnd_q <= req_i.round;
    end
    if (ld_lo) begin
      lo_q <= prod[LoW-1:0];
    end
    if (ld_hi) begin
      hi_q <= prod;
    end
    if (done_d) begin
      res_q <= sum[FracW+TotalW-1:FracW];
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// File: hdl/weighted_index_sampler.sv
`timescale 1ns / 1ps
// Weighted index sampler: running volume table with inverse-CDF lookup by binary search.
//
// Requests enter on start_i with operation_i, cell_volume_i and random_fraction_i; one is
// taken at a rising edge with start_i high and busy_o low. Each request gives exactly one
// result on cell_index_o, sample_count_o and status_o, marked by done_o for one cycle;
// the receiver takes it in that cycle and cannot stall the block.
// Clear, append, empty sample, fixed count and non-positive total: result in the cycle
// after the request, and the next request may follow in the cycle after acceptance.
// Density count: the shared multiplier runs its low product, high product and sum steps.
// Sample: the same multiplier steps, then one table read per halving step through the
// registered read port, plus a final probe; the number of halving steps is at most
// about log2 of the entry count (11 or 12 at 4096 entries).
// busy_o stays high until the result is out; a request is worked on one at a time.
// Configuration (density, fixed count mode, fixed count) is written through cfg_we_i,
// cfg_index_i and cfg_data_i; the user must write it only while the block is idle, which
// the block does not enforce. Unknown indexes are dropped. Reset empties the table, zeroes
// total, results and configuration, not table memory: only written entries are searched.
module weighted_index_sampler #(
  parameter int unsigned MAX_CELLS = wis_pkg::MaxCellsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          operation_i,
  input  logic signed [wis_pkg::VolW-1:0]     cell_volume_i,
  input  logic [wis_pkg::FracW-1:0]           random_fraction_i,
  input  logic                                cfg_we_i,
  input  logic [wis_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [wis_pkg::CfgDataW-1:0]        cfg_data_i,
  output logic                                done_o,
  output logic [wis_pkg::IndexOutW-1:0]       cell_index_o,
  output logic [wis_pkg::CountW-1:0]          sample_count_o,
  output logic [1:0]                          status_o
);

  localparam int unsigned IW        = $clog2(MAX_CELLS);
  localparam int unsigned CW        = $clog2(MAX_CELLS + 1);
  localparam int unsigned TotalW    = wis_pkg::TotalW;
  localparam int unsigned VolW      = wis_pkg::VolW;
  localparam int unsigned CountW    = wis_pkg::CountW;
  localparam int unsigned IndexOutW = wis_pkg::IndexOutW;

  function automatic logic [IW-1:0] mid_of(input logic [IW-1:0] lo, input logic [IW-1:0] hi);
    logic [IW:0] span;
    span   = {1'b0, hi - lo} + (IW+1)'(1);
    mid_of = lo + span[IW:1];
  endfunction

  wis_pkg::state_e  state_q, state_d;
  wis_pkg::op_e     op_q, op_d, op_in;
  wis_pkg::status_e status_q, status_d;

  logic [CW-1:0]             entry_cnt_q, entry_cnt_d, cnt_m1;
  logic signed [TotalW-1:0]  total_q, total_d, sum_append, vol_ext;
  logic signed [TotalW-1:0]  target_q, target_d;
  logic [IW-1:0]             lo_q, lo_d, hi_q, hi_d;
  logic                      pend_q, pend_d, fin_q, fin_d;
  logic                      done_q, done_d;
  logic [IW-1:0]             idx_q, idx_d;
  logic [CountW-1:0]         scnt_q, scnt_d, sat_cnt;
  logic [wis_pkg::FracW-1:0] density_q;
  logic                      use_fixed_q;
  logic [CountW-1:0]         fixed_cnt_q;

  logic                      accept, need_mul, total_pos, tab_empty, tab_full;
  wis_pkg::mul_req_t         mul_req;
  logic                      mul_done;
  logic signed [TotalW-1:0]  mul_res;

  logic                      ram_we;
  logic [IW-1:0]             ram_waddr, ram_raddr;
  logic [TotalW-1:0]         ram_rdata;

  logic [IW-1:0]             mid_cur, lo_u, hi_u, diff_u;
  logic                      cmp_le, far;
  logic [IW+IndexOutW-1:0]   idx_ext;

  assign op_in     = wis_pkg::op_e'(operation_i);
  assign accept    = start_i && (state_q == wis_pkg::S_IDLE);
  assign total_pos = total_q > $signed(TotalW'(0));
  assign tab_empty = entry_cnt_q == '0;
  assign tab_full  = entry_cnt_q >= CW'(MAX_CELLS);
  assign need_mul  = ((op_in == wis_pkg::OP_SAMPLE) && !tab_empty)
                  || ((op_in == wis_pkg::OP_COUNT) && total_pos && !use_fixed_q);

  assign vol_ext    = {{(TotalW-VolW){cell_volume_i[VolW-1]}}, cell_volume_i};
  assign sum_append = total_q + vol_ext;
  assign cnt_m1     = entry_cnt_q - CW'(1);
  assign sat_cnt    = (mul_res[TotalW-1:CountW] != '0) ? wis_pkg::CountMax
                                                       : mul_res[CountW-1:0];

  assign mul_req.valid = accept && need_mul;
  assign mul_req.round = op_in == wis_pkg::OP_COUNT;

  wis_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .x_i    (total_q),
    .y_i    ((op_in == wis_pkg::OP_COUNT) ? density_q : random_fraction_i),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  wis_table_ram #(
    .Depth (MAX_CELLS),
    .AddrW (IW),
    .DataW (TotalW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (sum_append),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Fold the returned probe into the bounds, then pick the next probe.
  always_comb begin
    mid_cur = mid_of(lo_q, hi_q);
    cmp_le  = target_q <= $signed(ram_rdata);
    lo_u    = lo_q;
    hi_u    = hi_q;
    if (pend_q && !fin_q) begin
      if (cmp_le) begin
        hi_u = mid_cur;
      end else begin
        lo_u = mid_cur;
      end
    end
    diff_u    = hi_u - lo_u;
    far       = diff_u > IW'(1);
    ram_raddr = far ? mid_of(lo_u, hi_u) : lo_u;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      wis_pkg::S_IDLE: begin
        if (accept && need_mul) begin
          state_d = wis_pkg::S_MUL;
        end
      end
      wis_pkg::S_MUL: begin
        if (mul_done) begin
          state_d = (op_q == wis_pkg::OP_SAMPLE) ? wis_pkg::S_SEARCH : wis_pkg::S_IDLE;
        end
      end
      wis_pkg::S_SEARCH: begin
        if (pend_q && fin_q) begin
          state_d = wis_pkg::S_IDLE;
        end
      end
      default: state_d = wis_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_d        = op_q;
    entry_cnt_d = entry_cnt_q;
    total_d     = total_q;
    target_d    = target_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    pend_d      = 1'b0;
    fin_d       = fin_q;
    done_d      = 1'b0;
    idx_d       = '0;
    scnt_d      = '0;
    status_d    = wis_pkg::STAT_OK;
    ram_we      = 1'b0;
    ram_waddr   = entry_cnt_q[IW-1:0];
    case (state_q)
      wis_pkg::S_IDLE: begin
        if (accept) begin
          op_d = op_in;
          case (op_in)
            wis_pkg::OP_CLEAR: begin
              entry_cnt_d = '0;
              total_d     = '0;
              done_d      = 1'b1;
            end
            wis_pkg::OP_APPEND: begin
              done_d = 1'b1;
              if (tab_full) begin
                status_d = wis_pkg::STAT_FULL;
              end else begin
                total_d     = sum_append;
                ram_we      = 1'b1;
                entry_cnt_d = entry_cnt_q + CW'(1);
                if (cell_volume_i <= $signed(VolW'(0))) begin
                  status_d = wis_pkg::STAT_NONPOS;
                end
              end
            end
            wis_pkg::OP_SAMPLE: begin
              if (tab_empty) begin
                done_d   = 1'b1;
                status_d = wis_pkg::STAT_EMPTY;
              end
            end
            wis_pkg::OP_COUNT: begin
              if (!total_pos) begin
                done_d = 1'b1;
              end else if (use_fixed_q) begin
                done_d = 1'b1;
                scnt_d = fixed_cnt_q;
              end
            end
            default: ;
          endcase
        end
      end
      wis_pkg::S_MUL: begin
        if (mul_done) begin
          if (op_q == wis_pkg::OP_SAMPLE) begin
            target_d = mul_res;
            lo_d     = '0;
            hi_d     = cnt_m1[IW-1:0];
          end else begin
            done_d = 1'b1;
            scnt_d = sat_cnt;
          end
        end
      end
      wis_pkg::S_SEARCH: begin
        if (pend_q && fin_q) begin
          done_d = 1'b1;
          idx_d  = cmp_le ? lo_q : hi_q;
        end else begin
          lo_d   = lo_u;
          hi_d   = hi_u;
          pend_d = 1'b1;
          fin_d  = !far;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wis_pkg::S_IDLE;
      op_q        <= wis_pkg::OP_CLEAR;
      entry_cnt_q <= '0;
      total_q     <= '0;
      pend_q      <= 1'b0;
      fin_q       <= 1'b0;
      done_q      <= 1'b0;
      idx_q       <= '0;
      scnt_q      <= '0;
      status_q    <= wis_pkg::STAT_OK;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      entry_cnt_q <= entry_cnt_d;
      total_q     <= total_d;
      pend_q      <= pend_d;
      fin_q       <= fin_d;
      done_q      <= done_d;
      idx_q       <= idx_d;
      scnt_q      <= scnt_d;
      status_q    <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q <= target_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      density_q   <= '0;
      use_fixed_q <= 1'b0;
      fixed_cnt_q <= '0;
    end else if (cfg_we_i) begin
      case (wis_pkg::cfg_idx_e'(cfg_index_i))
        wis_pkg::CFG_DENSITY:     density_q   <= cfg_data_i;
        wis_pkg::CFG_USE_FIXED:   use_fixed_q <= cfg_data_i[0];
        wis_pkg::CFG_FIXED_COUNT: fixed_cnt_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign idx_ext        = {{IndexOutW{1'b0}}, idx_q};
  assign busy_o         = state_q != wis_pkg::S_IDLE;
  assign done_o         = done_q;
  assign cell_index_o   = idx_ext[IndexOutW-1:0];
  assign sample_count_o = scnt_q;
  assign status_o       = status_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_cnt_q <= CW'(MAX_CELLS))
    else $error("entry count beyond table depth");

  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wis_pkg::S_SEARCH) |-> (lo_q <= hi_q))
    else $error("search bounds crossed");

  a_search_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wis_pkg::S_SEARCH) |-> (CW'(hi_q) < entry_cnt_q))
    else $error("search reaches an unwritten entry");

  a_mul_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == wis_pkg::S_MUL))
    else $error("multiplier result outside multiply wait");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != wis_pkg::S_IDLE) && (state_d == wis_pkg::S_IDLE) |-> done_d)
    else $error("long request finished without a result");
`endif

endmodule

// File: tb/weighted_index_sampler_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the weighted index sampler: queued requests, own predictor.
module weighted_index_sampler_test;

  localparam int unsigned CELLS       = wis_pkg::MaxCellsDefault;
  localparam int unsigned FILL_CELLS  = 640;
  localparam int unsigned RAND_ITEMS  = 1600;
  localparam int unsigned SETTLE      = 24;
  localparam int unsigned TAIL        = 40;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef enum logic [1:0] {
    K_REQ,
    K_CFG,
    K_DRAIN
  } step_kind_e;

  typedef struct {
    step_kind_e        kind;
    wis_pkg::op_e      op;
    logic [31:0]       vol;
    logic [31:0]       frac;
    wis_pkg::cfg_idx_e reg_idx;
    logic [31:0]       data;
  } stim_t;

  typedef struct {
    logic [wis_pkg::IndexOutW-1:0] pick;
    logic [wis_pkg::CountW-1:0]    count;
    wis_pkg::status_e              stat;
  } outcome_t;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [1:0]                       operation_i       = '0;
  logic signed [wis_pkg::VolW-1:0]  cell_volume_i     = '0;
  logic [wis_pkg::FracW-1:0]        random_fraction_i = '0;
  logic                             cfg_we_i          = 1'b0;
  logic [wis_pkg::CfgIdxW-1:0]      cfg_index_i       = '0;
  logic [wis_pkg::CfgDataW-1:0]     cfg_data_i        = '0;
  logic                             done_o;
  logic [wis_pkg::IndexOutW-1:0]    cell_index_o;
  logic [wis_pkg::CountW-1:0]       sample_count_o;
  logic [1:0]                       status_o;

  weighted_index_sampler DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .operation_i       (operation_i),
    .cell_volume_i     (cell_volume_i),
    .random_fraction_i (random_fraction_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .done_o            (done_o),
    .cell_index_o      (cell_index_o),
    .sample_count_o    (sample_count_o),
    .status_o          (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic signed [wis_pkg::TotalW-1:0] cum_sums [CELLS];
  logic signed [wis_pkg::TotalW-1:0] vol_sum    = '0;
  int unsigned                       entries    = 0;
  logic [31:0]                       dens       = '0;
  logic                              fixed_mode = 1'b0;
  logic [wis_pkg::CountW-1:0]        fixed_n    = '0;

  stim_t       pending_reqs [$];
  outcome_t    awaited      [$];
  int unsigned issued_cnt   = 0;
  int unsigned taken_cnt    = 0;
  int unsigned checked_cnt  = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cfg_writes   = 0;
  int unsigned random_items = 0;
  int unsigned op_seen      [4] = '{default: 0};
  int unsigned stat_seen    [4] = '{default: 0};
  int unsigned cycle_cnt    = 0;

  function automatic logic signed [81:0] widen(logic signed [wis_pkg::TotalW-1:0] v);
    return $signed({{(82-wis_pkg::TotalW){v[wis_pkg::TotalW-1]}}, v});
  endfunction

  function automatic outcome_t predict_outcome(wis_pkg::op_e op, logic signed [31:0] vol,
                                               logic [31:0] frac);
    outcome_t          res;
    logic signed [81:0] target;
    logic [81:0]       scaled;
    int unsigned       lo;
    int unsigned       hi;
    int unsigned       mid;
    res = '{pick: '0, count: '0, stat: wis_pkg::STAT_OK};
    case (op)
      wis_pkg::OP_CLEAR: begin
        entries = 0;
        vol_sum = '0;
      end
      wis_pkg::OP_APPEND: begin
        if (entries >= CELLS) begin
          res.stat = wis_pkg::STAT_FULL;
        end else begin
          vol_sum = vol_sum + $signed({{(wis_pkg::TotalW-32){vol[31]}}, vol});
          cum_sums[entries] = vol_sum;
          entries++;
          if (vol <= 0) res.stat = wis_pkg::STAT_NONPOS;
        end
      end
      wis_pkg::OP_SAMPLE: begin
        if (entries == 0) begin
          res.stat = wis_pkg::STAT_EMPTY;
        end else begin
          target = widen(vol_sum) * $signed({50'd0, frac});
          target = target >>> 32;
          lo = 0;
          hi = entries - 1;
          while (hi - lo > 1) begin
            mid = lo + (hi - lo + 1) / 2;
            if (target <= widen(cum_sums[mid])) hi = mid;
            else lo = mid;
          end
          res.pick = (target <= widen(cum_sums[lo])) ? lo[wis_pkg::IndexOutW-1:0]
                                                     : hi[wis_pkg::IndexOutW-1:0];
        end
      end
      default: begin
        if (vol_sum > 0) begin
          if (fixed_mode) begin
            res.count = fixed_n;
          end else begin
            scaled = ({34'd0, vol_sum} * {50'd0, dens} + 82'h8000_0000) >> 32;
            res.count = (scaled > {58'd0, wis_pkg::CountMax}) ? wis_pkg::CountMax
                                                              : scaled[wis_pkg::CountW-1:0];
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic note_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH at result %0d, %s: got %0h, want %0h", checked_cnt, what, got, want);
    mismatch_cnt++;
  endtask

  function automatic void push_request(wis_pkg::op_e op, logic [31:0] vol, logic [31:0] frac);
    stim_t s;
    s = '{kind: K_REQ, op: op, vol: vol, frac: frac, reg_idx: wis_pkg::CFG_DENSITY, data: '0};
    pending_reqs.push_back(s);
  endfunction

  function automatic void push_config(wis_pkg::cfg_idx_e idx, logic [31:0] data);
    stim_t s;
    s = '{kind: K_CFG, op: wis_pkg::OP_CLEAR, vol: '0, frac: '0, reg_idx: idx, data: data};
    pending_reqs.push_back(s);
  endfunction

  function automatic void push_drain();
    stim_t s;
    s = '{kind: K_DRAIN, op: wis_pkg::OP_CLEAR, vol: '0, frac: '0,
          reg_idx: wis_pkg::CFG_DENSITY, data: '0};
    pending_reqs.push_back(s);
  endfunction

  function automatic logic [31:0] draw_volume();
    case ($urandom_range(0, 15))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: return 32'h0000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h8000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      2: return -$urandom_range(0, 1 << 20);
      default: return $urandom_range(1, 1 << 22);
    endcase
  endfunction

  function automatic logic [31:0] draw_fraction();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_random(wis_pkg::op_e op);
    push_request(op, draw_volume(), draw_fraction());
    random_items++;
  endfunction

  function automatic void add_sequence();
    int unsigned steps;
    int unsigned roll;
    if ($urandom_range(0, 7) == 0) begin
      repeat (5) add_random(wis_pkg::op_e'($urandom_range(0, 3)));
      return;
    end
    add_random(wis_pkg::OP_CLEAR);
    steps = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 300) : $urandom_range(1, 24);
    repeat (steps) begin
      roll = $urandom_range(0, 9);
      if (roll < 7) add_random(wis_pkg::OP_APPEND);
      else if (roll < 9) add_random(wis_pkg::OP_SAMPLE);
      else add_random(wis_pkg::OP_COUNT);
    end
    repeat ($urandom_range(1, 6)) add_random(wis_pkg::OP_SAMPLE);
    repeat ($urandom_range(1, 2)) add_random(wis_pkg::OP_COUNT);
    if ($urandom_range(0, 5) == 0) push_drain();
  endfunction

  function automatic void fill_table();
    logic [31:0] vol;
    add_random(wis_pkg::OP_CLEAR);
    for (int unsigned i = 0; i < FILL_CELLS; i++) begin
      vol = ($urandom_range(0, 31) == 0) ? 32'd0 : $urandom_range(1, 1 << 12);
      push_request(wis_pkg::OP_APPEND, vol, $urandom);
      random_items++;
      if (i % 128 == 127) add_random(wis_pkg::OP_SAMPLE);
    end
    push_request(wis_pkg::OP_SAMPLE, '0, 32'h0000_0000);
    push_request(wis_pkg::OP_SAMPLE, '0, 32'hFFFF_FFFF);
    repeat (22) add_random(wis_pkg::OP_SAMPLE);
    repeat (3) add_random(wis_pkg::OP_APPEND);
    repeat (2) add_random(wis_pkg::OP_COUNT);
    add_random(wis_pkg::OP_CLEAR);
  endfunction

  function automatic void set_registers(int unsigned p);
    logic [31:0] d;
    case (p % 6)
      0: d = 32'hFFFF_FFFF;
      1: d = 32'h0000_0000;
      2: d = 32'h0001_0000;
      3: d = $urandom;
      4: d = 32'h0000_0001;
      default: d = $urandom_range(1, 1 << 18);
    endcase
    push_config(wis_pkg::CFG_DENSITY, d);
    push_config(wis_pkg::CFG_USE_FIXED, {31'd0, 1'((p / 2) % 2)});
    case (p % 3)
      0: d = {8'd0, wis_pkg::CountMax};
      1: d = 32'd0;
      default: d = $urandom_range(0, 32'h00FF_FFFF);
    endcase
    push_config(wis_pkg::CFG_FIXED_COUNT, d);
  endfunction

  // driver
  int unsigned idle_left = 0;
  int unsigned settle    = 0;
  logic        burst     = 1'b0;

  always @(negedge clk_i) begin
    stim_t head;
    logic  nxt_start;
    logic  nxt_we;
    if (rst_ni) begin
      nxt_start = start_i;
      nxt_we = 1'b0;
      if (start_i && taken_cnt == issued_cnt) nxt_start = 1'b0;
      if (!nxt_start) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending_reqs.size() > 0) begin
          head = pending_reqs[0];
          if (head.kind == K_REQ) begin
            void'(pending_reqs.pop_front());
            operation_i <= head.op;
            cell_volume_i <= head.vol;
            random_fraction_i <= head.frac;
            nxt_start = 1'b1;
            issued_cnt++;
            if ($urandom_range(0, 49) == 0) burst = !burst;
            idle_left = burst ? 0 : $urandom_range(0, 5);
          end else if (awaited.size() == 0 && !busy_o) begin
            if (settle < SETTLE) begin
              settle++;
            end else begin
              settle = 0;
              void'(pending_reqs.pop_front());
              if (head.kind == K_CFG) begin
                nxt_we = 1'b1;
                cfg_index_i <= head.reg_idx;
                cfg_data_i <= head.data;
              end
            end
          end else begin
            settle = 0;
          end
        end
      end
      start_i <= nxt_start;
      cfg_we_i <= nxt_we;
    end
  end

  // monitor: check results first, then track config writes and record new requests
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (awaited.size() == 0) begin
          note_mismatch("result with none awaited", status_o, 0);
        end else begin
          want = awaited.pop_front();
          if (cell_index_o !== want.pick) note_mismatch("cell_index", cell_index_o, want.pick);
          if (sample_count_o !== want.count)
            note_mismatch("sample_count", sample_count_o, want.count);
          if (status_o !== want.stat) note_mismatch("status", status_o, want.stat);
          stat_seen[want.stat]++;
        end
        checked_cnt++;
      end
      if (cfg_we_i) begin
        case (wis_pkg::cfg_idx_e'(cfg_index_i))
          wis_pkg::CFG_DENSITY:     dens = cfg_data_i;
          wis_pkg::CFG_USE_FIXED:   fixed_mode = cfg_data_i[0];
          wis_pkg::CFG_FIXED_COUNT: fixed_n = cfg_data_i[wis_pkg::CountW-1:0];
          default: ;
        endcase
        cfg_writes++;
      end
      if (start_i && !busy_o) begin
        awaited.push_back(predict_outcome(wis_pkg::op_e'(operation_i), cell_volume_i,
                                          random_fraction_i));
        op_seen[operation_i]++;
        taken_cnt++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    // empty table, then edge volumes under reset settings
    push_request(wis_pkg::OP_SAMPLE, 32'h0, 32'hFFFF_FFFF);
    push_request(wis_pkg::OP_COUNT, 32'h0, 32'h0);
    push_request(wis_pkg::OP_APPEND, 32'h0000_0000, 32'h0);
    push_request(wis_pkg::OP_APPEND, 32'h7FFF_FFFF, 32'h0);
    push_request(wis_pkg::OP_APPEND, 32'h8000_0000, 32'h0);
    push_request(wis_pkg::OP_APPEND, 32'h0000_0001, 32'h0);
    push_request(wis_pkg::OP_APPEND, 32'h0001_0000, 32'h0);
    push_request(wis_pkg::OP_SAMPLE, 32'h0, 32'h0000_0000);
    push_request(wis_pkg::OP_SAMPLE, 32'h0, 32'hFFFF_FFFF);
    push_request(wis_pkg::OP_SAMPLE, 32'h0, 32'h8000_0000);
    push_request(wis_pkg::OP_COUNT, 32'h0, 32'h0);
    push_request(wis_pkg::OP_CLEAR, 32'h0, 32'h0);
    push_request(wis_pkg::OP_SAMPLE, 32'h0, 32'h1234_5678);
    push_request(wis_pkg::OP_APPEND, 32'hFFFB_0000, 32'h0);
    push_request(wis_pkg::OP_SAMPLE, 32'h0, 32'hC000_0000);
    push_request(wis_pkg::OP_COUNT, 32'h0, 32'h0);
    push_request(wis_pkg::OP_CLEAR, 32'h0, 32'h0);
    push_request(wis_pkg::OP_APPEND, 32'h0003_8000, 32'h0);
    push_request(wis_pkg::OP_SAMPLE, 32'h0, 32'hFFFF_FFFF);
    push_request(wis_pkg::OP_COUNT, 32'h0, 32'h0);
    for (int unsigned p = 0; random_items < RAND_ITEMS || p < 6; p++) begin
      set_registers(p);
      if (p == 2) fill_table();
      else repeat (6) add_sequence();
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || awaited.size() != 0 || start_i);
    repeat (TAIL) @(posedge clk_i);
    if (awaited.size() != 0) note_mismatch("results still awaited", awaited.size(), 0);

    $display("Run: %0d requests (clear %0d, append %0d, sample %0d, count %0d), %0d reg writes",
             taken_cnt, op_seen[wis_pkg::OP_CLEAR], op_seen[wis_pkg::OP_APPEND],
             op_seen[wis_pkg::OP_SAMPLE], op_seen[wis_pkg::OP_COUNT], cfg_writes);
    $display("Results checked %0d: ok %0d, non-positive %0d, empty %0d, full %0d, mismatches %0d",
             checked_cnt, stat_seen[wis_pkg::STAT_OK], stat_seen[wis_pkg::STAT_NONPOS],
             stat_seen[wis_pkg::STAT_EMPTY], stat_seen[wis_pkg::STAT_FULL], mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: weighted_index_sampler.f
hdl/wis_pkg.sv
hdl/wis_table_ram.sv
hdl/wis_mul.sv
hdl/weighted_index_sampler.sv
tb/weighted_index_sampler_test.sv
